// ===== hdl/pcaw_pkg.sv =====
package pcaw_pkg;

    // field and state widths
    localparam int DATA_W    = 32;
    localparam int DT_W      = 31;
    localparam int SUM_W     = 48;
    localparam int FRAC_BITS = 16;

    // shared multiplier: |a| fits A_W bits, |b| fits B_W bits, b taken in two halves
    localparam int A_W    = DATA_W + 1;
    localparam int B_W    = SUM_W;
    localparam int HALF_W = B_W / 2;
    localparam int PP_W   = A_W + HALF_W;
    localparam int MAG_W  = 62;
    localparam int RES_W  = 64;
    localparam int PROD_W = (A_W + B_W > FRAC_BITS + MAG_W + 1) ? (A_W + B_W)
                                                                : (FRAC_BITS + MAG_W + 1);

    localparam logic signed [DATA_W-1:0] SETPOINT_MAX = 32'sd6553600;
    localparam logic signed [DATA_W-1:0] SETPOINT_MIN = -32'sd6553600;

    // configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_KP      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KI      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KD      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DT      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WINDUP  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OUT_MAX = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_OUT_MIN = 3'd6;

    // product selects, run in this order
    localparam int SEL_W = 3;
    localparam logic [SEL_W-1:0] MUL_P = 3'd0;  // kp * error
    localparam logic [SEL_W-1:0] MUL_W = 3'd1;  // ki * sum, windup check
    localparam logic [SEL_W-1:0] MUL_S = 3'd2;  // error * dt
    localparam logic [SEL_W-1:0] MUL_I = 3'd3;  // ki * sum, integral term
    localparam logic [SEL_W-1:0] MUL_D = 3'd4;  // kd * error change

    typedef struct packed {
        logic             accept;
        logic             check;
        logic             load;
        logic             mul_lo;
        logic             mul_hi;
        logic             fin;
        logic             post;
        logic             out_load;
        logic [SEL_W-1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic clear;
        logic reject;
    } t_stat;

endpackage

// ===== hdl/pcaw_ctrl.sv =====
module pcaw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pcaw_pkg::t_stat i_stat,
    output pcaw_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_LO    = 3'd3;
    localparam logic [2:0] S_HI    = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_POST  = 3'd6;
    localparam logic [2:0] S_FINAL = 3'd7;

    logic [2:0]                 r_state, n_state;
    logic [pcaw_pkg::SEL_W-1:0] r_sel, n_sel;
    logic                       r_out_valid, n_out_valid;
    logic                       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_sel       = pcaw_pkg::MUL_P;
                n_state     = (i_stat.clear || i_stat.reject) ? S_FINAL : S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_LO;
            end
            S_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_HI;
            end
            S_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_POST;
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                n_state    = S_LOAD;
                unique case (r_sel)
                    pcaw_pkg::MUL_P: n_sel = pcaw_pkg::MUL_W;
                    pcaw_pkg::MUL_W: n_sel = pcaw_pkg::MUL_S;
                    pcaw_pkg::MUL_S: n_sel = pcaw_pkg::MUL_I;
                    pcaw_pkg::MUL_I: n_sel = pcaw_pkg::MUL_D;
                    default:         n_state = S_FINAL;
                endcase
            end
            S_FINAL: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= pcaw_pkg::MUL_P;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/pcaw_dpath.sv =====
module pcaw_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcaw_pkg::t_cmd                    i_cmd,
    output pcaw_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_wr_en,
    input  logic [pcaw_pkg::REG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcaw_pkg::DATA_W-1:0]       i_cfg_wdata,
    input  logic                              i_op,
    input  logic [pcaw_pkg::DATA_W-1:0]       i_measured,
    input  logic [pcaw_pkg::DATA_W-1:0]       i_setpoint,
    output logic [pcaw_pkg::DATA_W-1:0]       o_drive,
    output logic                              o_setpoint_rejected
);

    localparam int DW = pcaw_pkg::DATA_W;
    localparam int AW = pcaw_pkg::A_W;
    localparam int BW = pcaw_pkg::B_W;
    localparam int HW = pcaw_pkg::HALF_W;
    localparam int SW = pcaw_pkg::SUM_W;
    localparam int RW = pcaw_pkg::RES_W;
    localparam int MW = pcaw_pkg::MAG_W;
    localparam int PW = pcaw_pkg::PROD_W;
    localparam int FB = pcaw_pkg::FRAC_BITS;
    localparam int TW = pcaw_pkg::DT_W;

    localparam logic [MW-1:0] TERM_CAP = {MW{1'b1}};
    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    // configuration
    logic signed [DW-1:0] r_kp, r_ki, r_kd, r_out_max, r_out_min;
    logic        [TW-1:0] r_dt, r_windup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_dt      <= TW'(1 << FB);
            r_windup  <= '0;
            r_out_max <= DW'(1 << FB);
            r_out_min <= -DW'(1 << FB);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pcaw_pkg::REG_KP:      r_kp      <= i_cfg_wdata;
                pcaw_pkg::REG_KI:      r_ki      <= i_cfg_wdata;
                pcaw_pkg::REG_KD:      r_kd      <= i_cfg_wdata;
                pcaw_pkg::REG_DT:      r_dt      <= i_cfg_wdata[TW-1:0];
                pcaw_pkg::REG_WINDUP:  r_windup  <= i_cfg_wdata[TW-1:0];
                pcaw_pkg::REG_OUT_MAX: r_out_max <= i_cfg_wdata;
                pcaw_pkg::REG_OUT_MIN: r_out_min <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // request latch
    logic                 r_op;
    logic signed [DW-1:0] r_meas, r_sp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_meas <= i_measured;
            r_sp   <= i_setpoint;
        end
    end

    // setpoint window and saturated error
    logic                 rejected;
    logic signed [DW:0]   diff;
    logic signed [DW-1:0] err_sat;

    assign rejected = (r_sp > pcaw_pkg::SETPOINT_MAX) || (r_sp < pcaw_pkg::SETPOINT_MIN);
    assign diff     = {r_sp[DW-1], r_sp} - {r_meas[DW-1], r_meas};
    always_comb begin
        if (diff[DW] != diff[DW-1]) begin
            err_sat = diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            err_sat = diff[DW-1:0];
        end
    end

    assign o_stat.clear  = r_op;
    assign o_stat.reject = rejected;

    // controller state
    logic signed [DW-1:0] r_prev;
    logic signed [SW-1:0] r_sum;

    // working registers
    logic signed [DW-1:0] r_err;
    logic signed [DW:0]   r_ediff;
    logic signed [RW-1:0] r_p, r_i, r_total, r_mres;
    logic        [MW-1:0] r_mmag;
    logic                 r_integ;
    logic                 r_zero, r_rej;
    logic        [AW-1:0] r_ua;
    logic        [BW-1:0] r_ub;
    logic                 r_neg;
    logic        [PW-1:0] r_prod;

    // operand select and magnitudes
    logic [AW-1:0] op_a, ua;
    logic [BW-1:0] op_b, ub;

    always_comb begin
        unique case (i_cmd.sel) inside
            pcaw_pkg::MUL_P: begin
                op_a = {r_kp[DW-1], r_kp};
                op_b = {{(BW-DW){r_err[DW-1]}}, r_err};
            end
            pcaw_pkg::MUL_W, pcaw_pkg::MUL_I: begin
                op_a = {r_ki[DW-1], r_ki};
                op_b = r_sum;
            end
            pcaw_pkg::MUL_S: begin
                op_a = {r_err[DW-1], r_err};
                op_b = {{(BW-TW){1'b0}}, r_dt};
            end
            pcaw_pkg::MUL_D: begin
                op_a = r_ediff;
                op_b = {{(BW-DW){r_kd[DW-1]}}, r_kd};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign ua = op_a[AW-1] ? (~op_a + AW'(1)) : op_a;
    assign ub = op_b[BW-1] ? (~op_b + BW'(1)) : op_b;

    // shared multiplier, one half of b per cycle
    localparam int PP_W_L = pcaw_pkg::PP_W;
    logic [HW-1:0] b_half;
    logic [PP_W_L-1:0] pp;

    assign b_half = i_cmd.mul_hi ? r_ub[BW-1:HW] : r_ub[HW-1:0];
    assign pp     = r_ua * b_half;

    // truncate fraction, cap magnitude, apply sign
    logic          cap;
    logic [MW-1:0] mag;
    logic signed [RW-1:0] mag_s;

    assign cap   = |r_prod[PW-1:FB+MW];
    assign mag   = cap ? TERM_CAP : r_prod[FB+MW-1:FB];
    assign mag_s = RW'(mag);

    // post-processing helpers
    logic signed [RW-1:0] sum_new;
    logic signed [SW-1:0] sum_sat;
    logic                 flip;

    assign sum_new = {{(RW-SW){r_sum[SW-1]}}, r_sum} + r_mres;
    always_comb begin
        if ((&sum_new[RW-1:SW-1]) || !(|sum_new[RW-1:SW-1])) begin
            sum_sat = sum_new[SW-1:0];
        end else begin
            sum_sat = sum_new[RW-1] ? SUM_MIN : SUM_MAX;
        end
    end

    assign flip = (r_p != '0) && (r_mres != '0) && (r_p[RW-1] != r_mres[RW-1]);

    // output clamp; the upper bound is tested last and wins
    logic signed [RW-1:0] min_ext, max_ext, clamp_lo, clamp_hi;

    assign min_ext  = {{(RW-DW){r_out_min[DW-1]}}, r_out_min};
    assign max_ext  = {{(RW-DW){r_out_max[DW-1]}}, r_out_max};
    assign clamp_lo = (r_total <= min_ext) ? min_ext : r_total;
    assign clamp_hi = (clamp_lo >= max_ext) ? max_ext : clamp_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_sum  <= '0;
        end else begin
            if (i_cmd.check && r_op) begin
                r_prev <= '0;
                r_sum  <= '0;
            end
            if (i_cmd.post) begin
                if (i_cmd.sel == pcaw_pkg::MUL_S && r_integ) begin
                    r_sum <= sum_sat;
                end
                if (i_cmd.sel == pcaw_pkg::MUL_D) begin
                    r_prev <= r_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_err  <= err_sat;
            r_zero <= r_op || rejected;
            r_rej  <= !r_op && rejected;
        end
        if (i_cmd.load) begin
            r_ua  <= ua;
            r_ub  <= ub;
            r_neg <= op_a[AW-1] ^ op_b[BW-1];
        end
        if (i_cmd.mul_lo) begin
            r_prod <= PW'(pp);
        end
        if (i_cmd.mul_hi) begin
            r_prod <= r_prod + (PW'(pp) << HW);
        end
        if (i_cmd.fin) begin
            r_mmag <= mag;
            r_mres <= r_neg ? -mag_s : mag_s;
        end
        if (i_cmd.post) begin
            case (i_cmd.sel)
                pcaw_pkg::MUL_P: begin
                    r_p     <= r_mres;
                    r_ediff <= {r_err[DW-1], r_err} - {r_prev[DW-1], r_prev};
                end
                pcaw_pkg::MUL_W: begin
                    r_integ <= !r_ki[DW-1] && (r_ki != '0)
                               && (r_mmag < MW'(r_windup));
                end
                pcaw_pkg::MUL_I: r_i     <= flip ? -r_mres : r_mres;
                pcaw_pkg::MUL_D: r_total <= r_p + r_i + r_mres;
                default: ;
            endcase
        end
    end

    // result register
    logic [DW-1:0] r_drive;
    logic          r_rej_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_drive   <= r_zero ? '0 : clamp_hi[DW-1:0];
            r_rej_out <= r_rej;
        end
    end

    assign o_drive             = r_drive;
    assign o_setpoint_rejected = r_rej_out;

endmodule

// ===== hdl/pid_controller_clamped_antiwindup_unit.sv =====
// Clamped PID step, Q16.16, conditional-integration anti-windup.
// A control step runs five products on one shared 33x24 multiplier, each through the
// load, lo, hi, fin and post states; a clear or a rejected setpoint skips them. A new
// request is taken only while the sequencer is idle.
// Reset (i_rst_n low, synchronous): state and output valid cleared, registers to defaults.
module pid_controller_clamped_antiwindup_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [pcaw_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [pcaw_pkg::DATA_W-1:0]    i_cfg_wdata,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [2*pcaw_pkg::DATA_W-1:0]  s_axis_tdata,   // [31:0] measured, [63:32] setpoint
    input  logic                           s_axis_tuser,   // [0] op (0 step, 1 clear)
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pcaw_pkg::DATA_W-1:0]    m_axis_tdata,   // [31:0] drive
    output logic                           m_axis_tuser    // [0] setpoint_rejected
);

    localparam int DW = pcaw_pkg::DATA_W;

    pcaw_pkg::t_cmd  cmd;
    pcaw_pkg::t_stat stat;

    // sequencer: idle -> check -> 5 x (load, lo, hi, fin, post) -> final; clear or reject skips to final.
    // The result register lets the next request in while a result waits.
    pcaw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: config registers, error/sum state, shared multiplier, clamp
    pcaw_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_op                (s_axis_tuser),
        .i_measured          (s_axis_tdata[DW-1:0]),
        .i_setpoint          (s_axis_tdata[2*DW-1:DW]),
        .o_drive             (m_axis_tdata),
        .o_setpoint_rejected (m_axis_tuser)
    );

endmodule

// ===== hdl/pcaw_chk.sv =====
module pcaw_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pcaw_pkg::DATA_W-1:0]    m_axis_tdata,
    input logic                           m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a rejected setpoint always reports zero drive
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("rejected setpoint with nonzero drive");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one request in flight: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule

bind pid_controller_clamped_antiwindup_unit pcaw_chk u_pcaw_chk (.*);

// ===== dv/tb_pid_controller_clamped_antiwindup_unit.sv =====
package pid_step_check_pkg;

    localparam longint unsigned TERM_CAP = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint          SUM_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          SUM_MIN  = -64'sh0000_8000_0000_0000;
    localparam longint          ERR_MAX  = 64'sh0000_0000_7FFF_FFFF;
    localparam longint          ERR_MIN  = -64'sh0000_0000_8000_0000;
    localparam int              SPLIT    = 24;

    typedef struct packed {
        logic [pcaw_pkg::DATA_W-1:0] drive;
        logic                        rejected;
    } t_drive_result;

    class pid_step_scoreboard;
        longint kp, ki, kd, dt, windup, out_max, out_min;
        longint last_error, error_sum;
        t_drive_result expected_drives[$];
        int failures;
        int steps, rejects, clears;

        function new();
            kp = 0;
            ki = 0;
            kd = 0;
            dt = 65536;
            windup = 0;
            out_max = 65536;
            out_min = -65536;
            last_error = 0;
            error_sum = 0;
            failures = 0;
            steps = 0;
            rejects = 0;
            clears = 0;
        endfunction

        // (a*b) >> FRAC_BITS toward zero, magnitude capped at 2^62-1
        function automatic longint scaled_product(longint a, longint b);
            longint unsigned ua, ub, hi, lo, m;
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            hi = ua * (ub >> SPLIT);
            lo = ua * (ub & 64'hFF_FFFF);
            if (hi > (TERM_CAP >> (SPLIT - pcaw_pkg::FRAC_BITS)))
                m = TERM_CAP;
            else
                m = (hi << (SPLIT - pcaw_pkg::FRAC_BITS)) + (lo >> pcaw_pkg::FRAC_BITS);
            if (m > TERM_CAP)
                m = TERM_CAP;
            return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
        endfunction

        function void set_register(logic [pcaw_pkg::REG_IDX_W-1:0] idx,
                                   logic [pcaw_pkg::DATA_W-1:0] value);
            case (idx)
                pcaw_pkg::REG_KP:      kp      = longint'($signed(value));
                pcaw_pkg::REG_KI:      ki      = longint'($signed(value));
                pcaw_pkg::REG_KD:      kd      = longint'($signed(value));
                pcaw_pkg::REG_DT:      dt      = longint'({33'd0, value[30:0]});
                pcaw_pkg::REG_WINDUP:  windup  = longint'({33'd0, value[30:0]});
                pcaw_pkg::REG_OUT_MAX: out_max = longint'($signed(value));
                pcaw_pkg::REG_OUT_MIN: out_min = longint'($signed(value));
                default: ;
            endcase
        endfunction

        function void note_request(logic op, logic [pcaw_pkg::DATA_W-1:0] measured,
                                   logic [pcaw_pkg::DATA_W-1:0] setpoint);
            longint sp, err, p, i, d, total, s, w;
            t_drive_result r;
            sp = longint'($signed(setpoint));
            r.drive = '0;
            r.rejected = 1'b0;
            if (op) begin
                last_error = 0;
                error_sum = 0;
                clears++;
            end else if (sp > longint'(pcaw_pkg::SETPOINT_MAX) ||
                         sp < longint'(pcaw_pkg::SETPOINT_MIN)) begin
                r.rejected = 1'b1;
                rejects++;
            end else begin
                err = sp - longint'($signed(measured));
                if (err > ERR_MAX) err = ERR_MAX;
                if (err < ERR_MIN) err = ERR_MIN;
                p = scaled_product(kp, err);
                w = scaled_product(ki, error_sum);
                if (w < 0) w = -w;
                if (ki > 0 && w < windup) begin
                    s = error_sum + scaled_product(err, dt);
                    if (s > SUM_MAX) s = SUM_MAX;
                    if (s < SUM_MIN) s = SUM_MIN;
                    error_sum = s;
                end
                i = scaled_product(ki, error_sum);
                if ((p < 0 && i > 0) || (p > 0 && i < 0))
                    i = -i;
                d = scaled_product(kd, err - last_error);
                total = p + i + d;
                if (total <= out_min) total = out_min;
                if (total >= out_max) total = out_max;
                last_error = err;
                r.drive = total[pcaw_pkg::DATA_W-1:0];
                steps++;
            end
            expected_drives.push_back(r);
        endfunction

        function void check_result(logic [pcaw_pkg::DATA_W-1:0] drive, logic rejected);
            t_drive_result e;
            if (expected_drives.size() == 0) begin
                $display("%0t: unexpected result drive %h rejected %b", $time, drive, rejected);
                failures++;
                return;
            end
            e = expected_drives.pop_front();
            if (drive !== e.drive) begin
                $display("%0t: drive mismatch, expected %h actual %h", $time, e.drive, drive);
                failures++;
            end
            if (rejected !== e.rejected) begin
                $display("%0t: setpoint_rejected mismatch, expected %b actual %b",
                         $time, e.rejected, rejected);
                failures++;
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

        function void flag_leftovers();
            if (expected_drives.size() != 0) begin
                $display("%0t: %0d results never arrived", $time, expected_drives.size());
                failures++;
            end
        endfunction
    endclass

endpackage

module tb_pid_controller_clamped_antiwindup_unit;
    import pcaw_pkg::*;
    import pid_step_check_pkg::*;

    // a step, a receiver stall, a sender gap and a settings change are all short next
    // to QUIET_LIMIT; anything quiet for much longer than those is a hang
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;   // a bit over the step latency
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0]  i_cfg_index = '0;
    logic [DATA_W-1:0]     i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [2*DATA_W-1:0]   s_axis_tdata = '0;   // [31:0] measured, [63:32] setpoint
    logic                  s_axis_tuser = 1'b0; // [0] op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;        // [31:0] drive
    logic                  m_axis_tuser;        // [0] setpoint_rejected

    pid_step_scoreboard sb = new();

    int quiet_cycles = 0;
    int burst_left = 0;
    int settings_written = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_hold_left = 0;

    pid_controller_clamped_antiwindup_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: check whatever is accepted at this edge, then pick the next
    // ready value. Modes: always ready, coin flip, or long on/off stretches.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (rx_mode_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(50, 400);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            default: begin
                if (rx_hold_left == 0) begin
                    m_axis_tready <= ~m_axis_tready;
                    rx_hold_left <= $urandom_range(1, 20);
                end else begin
                    rx_hold_left <= rx_hold_left - 1;
                end
            end
        endcase
    end

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sender pacing: bursts of back-to-back requests, then a random gap so the
    // next request lands on a different cycle of the step sequence.
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic op, input logic [DATA_W-1:0] measured,
                                input logic [DATA_W-1:0] setpoint);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {setpoint, measured};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, measured, setpoint);
        pace_sender();
    endtask

    // Stop sending, let every result drain, then give the pipeline time to settle
    // before touching the registers.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all seven registers, one per cycle; wr_en drops only after the last.
    task automatic program_regs(input logic [DATA_W-1:0] kp, ki, kd, dt, wu, omax, omin);
        logic [DATA_W-1:0]    vals[7];
        logic [REG_IDX_W-1:0] idx[7];
        vals = '{kp, ki, kd, dt, wu, omax, omin};
        idx = '{REG_KP, REG_KI, REG_KD, REG_DT, REG_WINDUP, REG_OUT_MAX, REG_OUT_MIN};
        for (int n = 0; n < 7; n++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[n];
            i_cfg_wdata <= vals[n];
            @(posedge i_clk);
            sb.set_register(idx[n], vals[n]);
        end
        i_cfg_wr_en <= 1'b0;
        settings_written++;
    endtask

    // Gains: mostly moderate (about +/-4.0) so the loop does real work, with
    // zero, both extremes and raw random words mixed in.
    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom;
            default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_period();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;           // bit 31 is dropped by the block
            default: return $urandom_range(1, 32'h2_0000);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_windup();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h100_0000);
        endcase
    endfunction

    // One random request. Setpoints are mostly legal; measured mostly tracks the
    // setpoint so the sum builds up, with raw words to hit every bit.
    task automatic send_random_request();
        logic              op;
        logic [DATA_W-1:0] sp, meas;
        op = ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 9))
            0: sp = $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: sp = SETPOINT_MAX;
                    1: sp = SETPOINT_MIN;
                    2: sp = SETPOINT_MAX + 1;
                    default: sp = SETPOINT_MIN - 1;
                endcase
            end
            default: sp = $urandom_range(0, 2 * SETPOINT_MAX) - SETPOINT_MAX;
        endcase
        case ($urandom_range(0, 9))
            0: meas = $urandom;
            1: meas = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: meas = sp + $urandom_range(0, 32'h20_0000) - 32'h10_0000;
        endcase
        send_request(op, meas, sp);
    endtask

    initial begin
        logic [DATA_W-1:0] omax, omin;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 30);

        // Directed, normal settings: kp 1.0, ki 0.5, kd 0.25, dt 1.0, clamps +/-100.
        program_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
                     32'h7FFF_FFFF, SETPOINT_MAX, SETPOINT_MIN);
        send_request(1'b0, 32'h0, 32'h0);
        send_request(1'b0, 32'h0, SETPOINT_MAX);
        send_request(1'b0, 32'h0, SETPOINT_MIN);
        send_request(1'b0, 32'h0, SETPOINT_MAX + 1);        // just above bound
        send_request(1'b0, 32'h0, SETPOINT_MIN - 1);        // just below bound
        send_request(1'b0, 32'h0, 32'h7FFF_FFFF);
        send_request(1'b0, 32'h0, 32'h8000_0000);
        send_request(1'b0, 32'h7FFF_FFFF, SETPOINT_MIN);    // error saturates low
        send_request(1'b0, 32'h8000_0000, SETPOINT_MAX);    // error saturates high
        send_request(1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);   // clear, setpoint ignored
        send_request(1'b0, 32'h0, 32'h0001_0000);
        send_request(1'b0, 32'h0000_8000, 32'h0001_0000);
        send_request(1'b0, 32'h0002_0000, 32'hFFFF_0000);
        wait_idle();

        // Directed: negative ki freezes the sum, clamps inverted so out_max wins.
        program_regs(32'hFFFF_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h0, 32'hFFFF_0000, 32'h0001_0000);
        send_request(1'b0, 32'h0, 32'h0002_0000);
        send_request(1'b0, 32'h0001_0000, 32'hFFFE_0000);
        send_request(1'b0, 32'h8000_0000, SETPOINT_MAX);
        send_request(1'b0, 32'h0, 32'h0000_8000);
        send_request(1'b1, 32'h0, 32'h0);
        send_request(1'b0, 32'h0, SETPOINT_MIN);
        send_request(1'b0, 32'h7FFF_FFFF, 32'h0);
        wait_idle();

        // Random phases; the first two pin every register to an extreme.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0) begin
                program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
            end else if (ph == 1) begin
                program_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                             32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        omax = 32'h7FFF_FFFF;
                        omin = 32'h8000_0000;
                    end
                    1: begin   // inverted
                        omax = -$urandom_range(1, 32'h100_0000);
                        omin = $urandom_range(1, 32'h100_0000);
                    end
                    2: begin
                        omax = $urandom;
                        omin = $urandom;
                    end
                    default: begin
                        omax = $urandom_range(1, 32'h100_0000);
                        omin = -$urandom_range(1, 32'h100_0000);
                    end
                endcase
                program_regs(pick_gain(), pick_gain(), pick_gain(), pick_period(),
                             pick_windup(), omax, omin);
            end
            repeat (PHASE_ITEMS) send_random_request();
            wait_idle();
        end

        sb.flag_leftovers();
        $display("Ran %0d control steps, %0d rejected setpoints and %0d clears",
                 sb.steps, sb.rejects, sb.clears);
        $display("over %0d register settings with random source gaps and sink stalls",
                 settings_written);
        if (sb.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
